FILE: hdl/ccmc_pkg.sv
// Package: types and constants for the catch motion controller.
package ccmc_pkg;

    localparam int unsigned GoalW = 16;
    localparam int unsigned PulseW = 18;
    localparam logic [PulseW-1:0] PULSE_MAX = {PulseW{1'b1}};

    typedef enum logic [1:0] {
        CMD_FLOOR = 2'd0,
        CMD_SIDE  = 2'd1,
        CMD_LIMIT = 2'd2,
        CMD_ESTOP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_CATCH = 2'd1,
        MODE_STOP  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_RANGE_X     = 3'd0,
        REG_RANGE_Y     = 3'd1,
        REG_FLOOR_SCALE = 3'd2,
        REG_SIDE_SCALE  = 3'd3,
        REG_SPEED_START = 3'd4,
        REG_SPEED_STEP  = 3'd5
    } reg_idx_t;

    localparam logic [7:0] BYTE_START  = 8'd252;
    localparam logic [7:0] BYTE_CENTRE = 8'd253;
    localparam logic [7:0] CENTRE_SPEED = 8'd50;
    localparam logic [7:0] PWM_TOP = 8'd255;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  rx_byte;
        logic [1:0]  switch_id;
        logic [15:0] left_count;
        logic [15:0] right_count;
    } in_item_t;

    typedef struct packed {
        logic        forward_valid;
        logic        forward_dest;
        logic [7:0]  forward_byte;
        logic        move_valid;
        logic        left_reverse;
        logic        right_reverse;
        logic [17:0] left_pulses;
        logic [17:0] right_pulses;
        logic [7:0]  pwm_period;
        logic [7:0]  pwm_compare;
        logic        halted;
        logic [2:0]  fault_code;
    } out_item_t;

    typedef struct packed {
        logic div_start;
        logic div_axis_y;
        logic move_start;
        logic move_centre;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic move_done;
    } dp_status_t;

endpackage

FILE: hdl/ccmc_divider.sv
// Iterative restoring divider for target scaling, one quotient bit a cycle.
module ccmc_divider
    import ccmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);
    logic [23:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [9:0]  trial;
    logic [8:0]  shifted;

    assign shifted = {rem_reg[7:0], quo_reg[23]};
    assign trial = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd24;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[9])
            begin
                rem_reg <= trial[8:0];
                quo_reg <= {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[22:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quotient = (dvs_reg == 8'd0) ? 16'd0 : quo_reg[15:0];
endmodule

FILE: hdl/ccmc_datapath.sv
// Datapath: registers, position state, target scaling and move computation.
module ccmc_datapath
    import ccmc_pkg::*;
#(
    parameter int POS_WIDTH = 24,
    parameter int SPEED_CAP = 240
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  in_item_t    item,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [15:0] floor_scale_q,
    output logic [15:0] side_scale_q,
    output out_item_t   move_out
);
    localparam logic [7:0] CAP = 8'(SPEED_CAP);

    logic [15:0] range_x_reg, range_y_reg;
    logic [7:0]  floor_scale_reg, side_scale_reg, speed_start_reg, speed_step_reg;
    logic [15:0] goal_x_reg, goal_y_reg;
    logic [7:0]  speed_reg;
    logic [POS_WIDTH-1:0] pos_x_reg, pos_y_reg;
    logic        lsign_reg, rsign_reg;
    logic [23:0] prod_reg;
    logic        axis_reg;
    logic [15:0] lc_reg, rc_reg;
    logic        div_go_reg;
    logic        div_done;
    logic [15:0] quotient;
    logic [1:0]  mstep_reg;
    logic        mcentre_reg;
    logic        mdone_reg;
    logic [POS_WIDTH+1:0] lp_reg, rp_reg;
    logic [7:0]  mspeed_reg;

    logic [15:0] lc, rc;
    logic signed [17:0] l_s, r_s, sum_s, dif_s;
    logic [15:0] tx, ty, cx, cy;
    logic signed [POS_WIDTH+1:0] dx, dy, lp, rp, lpa, rpa;
    logic [7:0]  spd, period;
    logic [8:0]  spd_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_x_reg     <= 16'd10000;
            range_y_reg     <= 16'd10000;
            floor_scale_reg <= 8'd250;
            side_scale_reg  <= 8'd250;
            speed_start_reg <= 8'd220;
            speed_step_reg  <= 8'd5;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RANGE_X:     range_x_reg <= cfg_data;
                REG_RANGE_Y:     range_y_reg <= cfg_data;
                REG_FLOOR_SCALE: floor_scale_reg <= cfg_data[7:0];
                REG_SIDE_SCALE:  side_scale_reg <= cfg_data[7:0];
                REG_SPEED_START: speed_start_reg <= cfg_data[7:0];
                REG_SPEED_STEP:  speed_step_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign floor_scale_q = {8'd0, floor_scale_reg};
    assign side_scale_q  = {8'd0, side_scale_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= cmd.div_start;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            axis_reg <= cmd.div_axis_y;
            prod_reg <= item.rx_byte * (cmd.div_axis_y ? range_y_reg : range_x_reg);
            lc_reg   <= item.left_count;
            rc_reg   <= item.right_count;
        end
    end

    ccmc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (prod_reg),
        .divisor  (axis_reg ? side_scale_reg : floor_scale_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign lc = cmd.move_centre ? item.left_count : lc_reg;
    assign rc = cmd.move_centre ? item.right_count : rc_reg;
    assign l_s = lsign_reg ? $signed({2'b00, lc})
                           : -$signed({2'b00, lc});
    assign r_s = rsign_reg ? $signed({2'b00, rc})
                           : -$signed({2'b00, rc});
    assign sum_s = (l_s + r_s) / 2;
    assign dif_s = (l_s - r_s) / 2;

    assign tx = mcentre_reg ? {1'b0, range_x_reg[15:1]} : goal_x_reg;
    assign ty = mcentre_reg ? {1'b0, range_y_reg[15:1]} : goal_y_reg;
    assign cx = (tx > range_x_reg) ? range_x_reg : tx;
    assign cy = (ty > range_y_reg) ? range_y_reg : ty;
    assign dx = $signed({{(POS_WIDTH-14){1'b0}}, cx}) - $signed({{2{pos_x_reg[POS_WIDTH-1]}}, pos_x_reg});
    assign dy = $signed({{(POS_WIDTH-14){1'b0}}, cy}) - $signed({{2{pos_y_reg[POS_WIDTH-1]}}, pos_y_reg});
    assign lp = dx + dy;
    assign rp = dx - dy;
    assign lpa = lp_reg[POS_WIDTH+1] ? -$signed(lp_reg) : $signed(lp_reg);
    assign rpa = rp_reg[POS_WIDTH+1] ? -$signed(rp_reg) : $signed(rp_reg);
    assign spd = (mspeed_reg > CAP) ? CAP : mspeed_reg;
    assign period = PWM_TOP - spd;
    assign spd_sum = {1'b0, speed_reg} + {1'b0, speed_step_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            speed_reg  <= 8'd220;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            lsign_reg  <= 1'b1;
            rsign_reg  <= 1'b1;
            mstep_reg  <= '0;
            mcentre_reg <= 1'b0;
            mdone_reg  <= 1'b0;
            mspeed_reg <= '0;
            lp_reg     <= '0;
            rp_reg     <= '0;
        end
        else
        begin
            mdone_reg <= 1'b0;
            if (div_done)
            begin
                if (axis_reg)
                    goal_y_reg <= quotient;
                else
                    goal_x_reg <= quotient;
            end
            if (cmd.move_start)
            begin
                mcentre_reg <= cmd.move_centre;
                mspeed_reg  <= cmd.move_centre ? CENTRE_SPEED : speed_reg;
                pos_x_reg <= pos_x_reg + POS_WIDTH'(sum_s);
                pos_y_reg <= pos_y_reg + POS_WIDTH'(dif_s);
                mstep_reg <= 2'd1;
            end
            else if (mstep_reg == 2'd1)
            begin
                lp_reg <= lp;
                rp_reg <= rp;
                lsign_reg <= (lp > 0);
                rsign_reg <= (rp > 0);
                mstep_reg <= 2'd2;
            end
            else if (mstep_reg == 2'd2)
            begin
                mstep_reg <= 2'd0;
                mdone_reg <= 1'b1;
                if (mcentre_reg)
                    speed_reg <= speed_start_reg;
                else
                    speed_reg <= spd_sum[8] ? 8'hFF : spd_sum[7:0];
            end
        end
    end

    always_comb
    begin
        move_out = '0;
        move_out.move_valid    = 1'b1;
        move_out.left_reverse  = lp_reg[POS_WIDTH+1] || (lp_reg == '0);
        move_out.right_reverse = rp_reg[POS_WIDTH+1] || (rp_reg == '0);
        move_out.left_pulses   = (lpa > $signed({{(POS_WIDTH-16){1'b0}}, PULSE_MAX}))
                                 ? PULSE_MAX : lpa[17:0];
        move_out.right_pulses  = (rpa > $signed({{(POS_WIDTH-16){1'b0}}, PULSE_MAX}))
                                 ? PULSE_MAX : rpa[17:0];
        move_out.pwm_period    = period;
        move_out.pwm_compare   = 8'd1 + {1'b0, period[7:1]};
    end

    assign status.div_done  = div_done;
    assign status.move_done = mdone_reg;
endmodule

FILE: hdl/ccmc_controller.sv
// Controller: mode state, pairing flags and event sequencing.
module ccmc_controller
    import ccmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    item,
    input  logic [15:0] floor_scale_q,
    input  logic [15:0] side_scale_q,
    input  dp_status_t  status,
    input  out_item_t   move_res,
    input  logic        out_stall,
    output logic        ready,
    output dp_cmd_t     cmd,
    output out_item_t   result,
    output logic        out_valid
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MOVE = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   fr_reg, sr_reg;
    logic   fr_set, sr_set;
    logic [2:0] code_reg, code_next;
    out_item_t res_reg, res_next, acc_res;
    logic   pair_reg, centre_reg;
    logic   pair_next, centre_next;
    logic   acc;
    logic   is_floor_pred, is_side_pred;

    assign ready = (state_reg == ST_IDLE);
    assign acc = in_valid && !in_stall;
    assign is_floor_pred = {8'd0, item.rx_byte} <= floor_scale_q;
    assign is_side_pred  = {8'd0, item.rx_byte} <= side_scale_q;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && mode_reg != MODE_STOP)
                begin
                    if (mode_reg == MODE_CATCH && item.command == CMD_FLOOR && is_floor_pred)
                    begin
                        cmd.div_start = 1'b1;
                        state_next = ST_DIV;
                    end
                    else if (mode_reg == MODE_CATCH && item.command == CMD_SIDE && is_side_pred)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_axis_y = 1'b1;
                        state_next = ST_DIV;
                    end
                    else if (mode_reg == MODE_CATCH && item.command == CMD_SIDE
                             && item.rx_byte == BYTE_CENTRE)
                    begin
                        cmd.move_start = 1'b1;
                        cmd.move_centre = 1'b1;
                        state_next = ST_MOVE;
                    end
                    else
                        state_next = ST_OUT;
                end
                else if (acc)
                    state_next = ST_OUT;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    if (pair_reg)
                    begin
                        cmd.move_start = 1'b1;
                        state_next = ST_MOVE;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_MOVE:
                if (status.move_done)
                    state_next = ST_OUT;
            ST_OUT:
                state_next = ST_HOLD;
            ST_HOLD:
                if (!out_stall)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        acc_res = '0;
        pair_next = 1'b0;
        centre_next = 1'b0;
        mode_next = mode_reg;
        code_next = code_reg;
        fr_set = 1'b0;
        sr_set = 1'b0;
        if (mode_reg != MODE_STOP)
        begin
            unique case (item.command)
                CMD_FLOOR:
                    if (mode_reg == MODE_CATCH)
                    begin
                        acc_res.forward_valid = 1'b1;
                        acc_res.forward_dest = 1'b1;
                        acc_res.forward_byte = item.rx_byte;
                        if (is_floor_pred)
                        begin
                            fr_set = 1'b1;
                            pair_next = sr_reg;
                        end
                    end
                CMD_SIDE:
                    if (mode_reg == MODE_CATCH)
                    begin
                        acc_res.forward_valid = 1'b1;
                        acc_res.forward_byte = item.rx_byte;
                        if (is_side_pred)
                        begin
                            sr_set = 1'b1;
                            pair_next = fr_reg;
                        end
                        else if (item.rx_byte == BYTE_CENTRE)
                        begin
                            mode_next = MODE_READY;
                            centre_next = 1'b1;
                        end
                    end
                    else if (item.rx_byte == BYTE_START)
                    begin
                        acc_res.forward_valid = 1'b1;
                        acc_res.forward_byte = item.rx_byte;
                        mode_next = MODE_CATCH;
                    end
                CMD_LIMIT:
                begin
                    mode_next = MODE_STOP;
                    code_next = {1'b0, item.switch_id} + 3'd1;
                end
                default:
                begin
                    mode_next = MODE_STOP;
                    code_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (state_reg == ST_IDLE && acc)
            res_next = acc_res;
        if (state_reg == ST_MOVE && status.move_done)
        begin
            res_next.move_valid    = move_res.move_valid;
            res_next.left_reverse  = move_res.left_reverse;
            res_next.right_reverse = move_res.right_reverse;
            res_next.left_pulses   = move_res.left_pulses;
            res_next.right_pulses  = move_res.right_pulses;
            res_next.pwm_period    = move_res.pwm_period;
            res_next.pwm_compare   = move_res.pwm_compare;
        end
        if (state_reg == ST_OUT)
        begin
            res_next.halted = (mode_reg == MODE_STOP);
            res_next.fault_code = (mode_reg == MODE_STOP) ? code_reg : 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_READY;
            fr_reg    <= 1'b0;
            sr_reg    <= 1'b0;
            code_reg  <= '0;
            pair_reg  <= 1'b0;
            centre_reg <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            if (state_reg == ST_IDLE && acc)
            begin
                pair_reg <= pair_next;
                centre_reg <= centre_next;
                mode_reg <= mode_next;
                code_reg <= code_next;
                if (fr_set)
                    fr_reg <= 1'b1;
                if (sr_set)
                    sr_reg <= 1'b1;
            end
            if (state_reg == ST_MOVE && status.move_done && !centre_reg)
            begin
                fr_reg <= 1'b0;
                sr_reg <= 1'b0;
            end
        end
    end

    assign result = res_reg;
    assign out_valid = (state_reg == ST_HOLD);

`ifndef SYNTHESIS
    a_out_only_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_HOLD)
        else $error("out_valid outside hold");
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(mode_reg) == MODE_STOP |-> mode_reg == MODE_STOP)
        else $error("left stopped mode");
    a_move_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_start |-> state_reg == ST_IDLE || state_reg == ST_DIV)
        else $error("move started in wrong state");
`endif
endmodule

FILE: hdl/corexy_catch_motion_controller.sv
// Top level: catch motion controller with one transaction in flight at a time.
// Path: a forward-only or fault event passes the output and hold states; a centre
// move adds the move state, and a prediction byte adds the scaling divider, then
// the move state when it pairs a move. Events are not taken while one is in flight.
// Reset: asynchronous active-low; registers take defaults, mode ready, position zero.
module corexy_catch_motion_controller
    import ccmc_pkg::*;
#(
    parameter int POS_WIDTH = 24,
    parameter int SPEED_CAP = 240
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    dp_cmd_t    cmd;
    dp_status_t status;
    out_item_t  move_res;
    logic [15:0] fsq, ssq;
    logic       ready;

    assign in_stall = !ready;
    assign cfg_ready = 1'b1;

    ccmc_datapath #(.POS_WIDTH(POS_WIDTH), .SPEED_CAP(SPEED_CAP)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .item(in_data), .cmd(cmd), .status(status),
        .floor_scale_q(fsq), .side_scale_q(ssq), .move_out(move_res)
    );

    ccmc_controller u_ctl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .item(in_data),
        .floor_scale_q(fsq), .side_scale_q(ssq),
        .status(status), .move_res(move_res), .out_stall(out_stall),
        .ready(ready), .cmd(cmd), .result(out_data), .out_valid(out_valid)
    );
endmodule

FILE: sim/ccmc_checker.sv
// Checker: predicts catch controller results from accepted events and compares them.
module ccmc_checker
    import ccmc_pkg::*;
(
    input  logic        clk,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int POS_W = 24;
    localparam int SPEED_LIMIT = 240;
    localparam longint PULSE_TOP = 262143;

    logic [15:0] range_x = 16'd10000;
    logic [15:0] range_y = 16'd10000;
    logic [7:0]  floor_scale = 8'd250;
    logic [7:0]  side_scale = 8'd250;
    logic [7:0]  speed_start = 8'd220;
    logic [7:0]  speed_step = 8'd5;

    mode_t              mode = MODE_READY;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic [15:0]        goal_x = '0;
    logic [15:0]        goal_y = '0;
    logic               floor_ready = 1'b0;
    logic               side_ready = 1'b0;
    logic [7:0]         catch_speed = 8'd220;
    logic               left_fwd = 1'b1;
    logic               right_fwd = 1'b1;
    logic [2:0]         stop_code = '0;

    out_item_t expected_results[$];

    initial errors = 0;
    assign pending = expected_results.size();

    task automatic report(string field, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", field, got, want);
    endtask

    function automatic logic [15:0] scale_goal(logic [7:0] rx, logic [15:0] range,
                                               logic [7:0] scale);
        int unsigned prod;
        prod = rx * range;
        return (scale == 0) ? 16'd0 : 16'(prod / scale);
    endfunction

    function automatic longint abs_sat(longint v);
        longint a;
        a = (v < 0) ? -v : v;
        return (a > PULSE_TOP) ? PULSE_TOP : a;
    endfunction

    function automatic void plan_move(logic [15:0] tx, logic [15:0] ty, logic [7:0] spd,
                                      logic [15:0] lc, logic [15:0] rc,
                                      inout out_item_t r);
        longint l, rr, dx, dy, lp, rp;
        logic [7:0] period;
        l = left_fwd ? longint'(lc) : -longint'(lc);
        rr = right_fwd ? longint'(rc) : -longint'(rc);
        pos_x = pos_x + (l + rr) / 2;
        pos_y = pos_y + (l - rr) / 2;
        if (spd > SPEED_LIMIT)
            spd = SPEED_LIMIT;
        if (tx > range_x)
            tx = range_x;
        if (ty > range_y)
            ty = range_y;
        dx = longint'(tx) - longint'(pos_x);
        dy = longint'(ty) - longint'(pos_y);
        lp = dx + dy;
        rp = dx - dy;
        left_fwd = lp > 0;
        right_fwd = rp > 0;
        period = 8'd255 - spd;
        r.move_valid = 1'b1;
        r.left_reverse = !left_fwd;
        r.right_reverse = !right_fwd;
        r.left_pulses = 18'(abs_sat(lp));
        r.right_pulses = 18'(abs_sat(rp));
        r.pwm_period = period;
        r.pwm_compare = 8'd1 + period / 2;
    endfunction

    function automatic void paired_move(in_item_t it, inout out_item_t r);
        int unsigned s;
        plan_move(goal_x, goal_y, catch_speed, it.left_count, it.right_count, r);
        floor_ready = 1'b0;
        side_ready = 1'b0;
        s = catch_speed + speed_step;
        catch_speed = (s > 255) ? 8'd255 : 8'(s);
    endfunction

    function automatic out_item_t predict_event(in_item_t it);
        out_item_t r;
        r = '0;
        if (mode != MODE_STOP) begin
            case (cmd_t'(it.command))
                CMD_FLOOR:
                begin
                    if (mode == MODE_CATCH) begin
                        r.forward_valid = 1'b1;
                        r.forward_dest = 1'b1;
                        r.forward_byte = it.rx_byte;
                        if (it.rx_byte <= floor_scale) begin
                            floor_ready = 1'b1;
                            goal_x = scale_goal(it.rx_byte, range_x, floor_scale);
                            if (side_ready)
                                paired_move(it, r);
                        end
                    end
                end
                CMD_SIDE:
                begin
                    if (mode == MODE_CATCH) begin
                        r.forward_valid = 1'b1;
                        r.forward_dest = 1'b0;
                        r.forward_byte = it.rx_byte;
                        if (it.rx_byte <= side_scale) begin
                            side_ready = 1'b1;
                            goal_y = scale_goal(it.rx_byte, range_y, side_scale);
                            if (floor_ready)
                                paired_move(it, r);
                        end
                        else if (it.rx_byte == BYTE_CENTRE) begin
                            mode = MODE_READY;
                            catch_speed = speed_start;
                            plan_move(range_x / 2, range_y / 2, CENTRE_SPEED,
                                      it.left_count, it.right_count, r);
                        end
                    end
                    else if (it.rx_byte == BYTE_START) begin
                        r.forward_valid = 1'b1;
                        r.forward_byte = it.rx_byte;
                        mode = MODE_CATCH;
                    end
                end
                CMD_LIMIT:
                begin
                    mode = MODE_STOP;
                    stop_code = 3'(it.switch_id) + 3'd1;
                end
                default:
                begin
                    mode = MODE_STOP;
                    stop_code = '0;
                end
            endcase
        end
        r.halted = (mode == MODE_STOP);
        r.fault_code = (mode == MODE_STOP) ? stop_code : 3'd0;
        return r;
    endfunction

    always @(posedge clk) begin
        out_item_t want;
        if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_RANGE_X:     range_x = cfg_data;
                REG_RANGE_Y:     range_y = cfg_data;
                REG_FLOOR_SCALE: floor_scale = cfg_data[7:0];
                REG_SIDE_SCALE:  side_scale = cfg_data[7:0];
                REG_SPEED_START: speed_start = cfg_data[7:0];
                REG_SPEED_STEP:  speed_step = cfg_data[7:0];
                default: ;
            endcase
        end
        if (in_valid && !in_stall)
            expected_results.push_back(predict_event(in_data));
        if (out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected transaction", 1, 0);
            end
            else begin
                want = expected_results.pop_front();
                if (out_data.forward_valid !== want.forward_valid)
                    report("forward_valid", out_data.forward_valid, want.forward_valid);
                if (out_data.forward_dest !== want.forward_dest)
                    report("forward_dest", out_data.forward_dest, want.forward_dest);
                if (out_data.forward_byte !== want.forward_byte)
                    report("forward_byte", out_data.forward_byte, want.forward_byte);
                if (out_data.move_valid !== want.move_valid)
                    report("move_valid", out_data.move_valid, want.move_valid);
                if (out_data.left_reverse !== want.left_reverse)
                    report("left_reverse", out_data.left_reverse, want.left_reverse);
                if (out_data.right_reverse !== want.right_reverse)
                    report("right_reverse", out_data.right_reverse, want.right_reverse);
                if (out_data.left_pulses !== want.left_pulses)
                    report("left_pulses", out_data.left_pulses, want.left_pulses);
                if (out_data.right_pulses !== want.right_pulses)
                    report("right_pulses", out_data.right_pulses, want.right_pulses);
                if (out_data.pwm_period !== want.pwm_period)
                    report("pwm_period", out_data.pwm_period, want.pwm_period);
                if (out_data.pwm_compare !== want.pwm_compare)
                    report("pwm_compare", out_data.pwm_compare, want.pwm_compare);
                if (out_data.halted !== want.halted)
                    report("halted", out_data.halted, want.halted);
                if (out_data.fault_code !== want.fault_code)
                    report("fault_code", out_data.fault_code, want.fault_code);
            end
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top: drives events and register writes into the catch controller.
module tb;
    import ccmc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    logic [7:0]  cur_floor_scale = 8'd250;
    logic [7:0]  cur_side_scale = 8'd250;

    corexy_catch_motion_controller uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ccmc_checker u_checker (
        .clk(clk), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("corexy_catch_motion_controller regression: fail");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall)
            stall_left = quiet ? 0 : $urandom_range(0, 19);
        else if (stall_left > 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    task automatic send_event(in_item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_byte(cmd_t c, logic [7:0] b, logic [15:0] lc, logic [15:0] rc);
        in_item_t it;
        it.command = c;
        it.rx_byte = b;
        it.switch_id = 2'($urandom);
        it.left_count = lc;
        it.right_count = rc;
        send_event(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(logic [15:0] rx, logic [15:0] ry, logic [7:0] fs,
                             logic [7:0] ss, logic [7:0] st, logic [7:0] sp);
        write_reg(REG_RANGE_X, rx);
        write_reg(REG_RANGE_Y, ry);
        write_reg(REG_FLOOR_SCALE, {8'd0, fs});
        write_reg(REG_SIDE_SCALE, {8'd0, ss});
        write_reg(REG_SPEED_START, {8'd0, st});
        write_reg(REG_SPEED_STEP, {8'd0, sp});
        cfg_valid <= 1'b0;
        cur_floor_scale = fs;
        cur_side_scale = ss;
    endtask

    function automatic logic [15:0] draw_count();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return 16'($urandom_range(0, 3000));
        else if (k < 8)
            return 16'($urandom);
        else
            return (k == 8) ? 16'd0 : 16'hFFFF;
    endfunction

    function automatic logic [7:0] draw_prediction(logic [7:0] scale);
        return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, scale)) : 8'($urandom);
    endfunction

    task automatic send_random();
        int k;
        k = $urandom_range(0, 99);
        if (k < 8)
            send_byte(CMD_SIDE, BYTE_START, draw_count(), draw_count());
        else if (k < 13)
            send_byte(CMD_SIDE, BYTE_CENTRE, draw_count(), draw_count());
        else if (k < 52)
            send_byte(CMD_FLOOR, draw_prediction(cur_floor_scale), draw_count(), draw_count());
        else if (k < 92)
            send_byte(CMD_SIDE, draw_prediction(cur_side_scale), draw_count(), draw_count());
        else
            send_byte(cmd_t'($urandom_range(0, 1)), 8'($urandom), draw_count(), draw_count());
    endtask

    initial begin
        in_item_t it;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(CMD_FLOOR, 8'd10, 16'd0, 16'd0);
        send_byte(CMD_SIDE, 8'd10, 16'd0, 16'd0);
        send_byte(CMD_SIDE, BYTE_START, 16'd0, 16'd0);
        send_byte(CMD_FLOOR, 8'd0, 16'd0, 16'd0);
        send_byte(CMD_SIDE, 8'd0, 16'd0, 16'd0);
        send_byte(CMD_FLOOR, 8'd250, 16'hFFFF, 16'hFFFF);
        send_byte(CMD_SIDE, 8'd250, 16'hFFFF, 16'd0);
        send_byte(CMD_FLOOR, 8'd251, 16'd0, 16'hFFFF);
        send_byte(CMD_SIDE, 8'd251, 16'd1, 16'd1);
        send_byte(CMD_SIDE, BYTE_START, 16'd5, 16'd7);
        send_byte(CMD_SIDE, 8'd254, 16'd0, 16'd0);
        send_byte(CMD_SIDE, 8'd255, 16'd0, 16'd0);
        send_byte(CMD_FLOOR, 8'd255, 16'd0, 16'd0);
        send_byte(CMD_FLOOR, 8'd125, 16'd100, 16'd3);
        send_byte(CMD_SIDE, BYTE_CENTRE, 16'hFFFF, 16'hFFFF);
        send_byte(CMD_SIDE, 8'd100, 16'd0, 16'd0);
        send_byte(CMD_SIDE, BYTE_START, 16'd0, 16'd0);
        send_byte(CMD_SIDE, 8'd7, 16'd1234, 16'd4321);
        send_byte(CMD_FLOOR, 8'd200, 16'd8, 16'd9);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure(16'd10000, 16'd10000, 8'd250, 8'd250, 8'd220, 8'd5);
                1: configure(16'hFFFF, 16'hFFFF, 8'd251, 8'd251, 8'd255, 8'd255);
                2: configure(16'd0, 16'd0, 8'd1, 8'd1, 8'd0, 8'd0);
                3: configure(16'hFFFF, 16'd1, 8'd7, 8'd200, 8'd240, 8'd1);
                4: configure(16'($urandom), 16'($urandom), 8'($urandom_range(1, 251)),
                             8'($urandom_range(1, 251)), 8'($urandom), 8'($urandom));
                default: configure(16'd10000, 16'd300, 8'd251, 8'd1, 8'd100, 8'd30);
            endcase
            for (int n = 0; n < 88; n++) begin
                if (n % 30 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                send_random();
            end
            quiet = 1'b0;
            drain();
        end

        send_byte(CMD_SIDE, BYTE_START, 16'd0, 16'd0);
        it = '0;
        it.command = CMD_LIMIT;
        it.switch_id = 2'($urandom);
        send_event(it);
        send_byte(CMD_SIDE, 8'd20, 16'd1, 16'd1);
        send_byte(CMD_FLOOR, 8'd20, 16'd1, 16'd1);
        send_byte(CMD_ESTOP, 8'd0, 16'd0, 16'd0);
        it.command = CMD_LIMIT;
        it.switch_id = ~it.switch_id;
        send_event(it);
        drain();

        if (errors == 0 && pending == 0)
            $display("corexy_catch_motion_controller regression: pass");
        else
            $display("corexy_catch_motion_controller regression: fail");
        $finish;
    end

endmodule
